/* hw/rtl/iirtdf2_pkg.sv */
// Shared types and constants for the transposed direct form II IIR filter.
// No dependencies; used by iirtdf2_cell, iir_filter_transposed_df2_core and tb_top.
`timescale 1ns / 1ps

package iirtdf2_pkg;

  localparam int SMP_W   = 16;  // sample width
  localparam int COEF_W  = 18;  // Q3.14 coefficient width
  localparam int DLY_W   = 40;  // delay element width
  localparam int PROD_W  = SMP_W + COEF_W;
  localparam int FRAC_W  = 14;
  localparam int ORD_W   = 2;
  localparam int IDX_W   = 2;
  localparam int CMD_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;
  localparam int NUM_TAPS   = 3;  // b1..b3 / a1..a3 registers

  localparam logic signed [COEF_W-1:0] B0_RESET = 18'sd16384;

  typedef enum logic [CMD_W-1:0] {
    CMD_FILTER = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORDER = 3'd0,
    CFG_B0    = 3'd1,
    CFG_B1    = 3'd2,
    CFG_B2    = 3'd3,
    CFG_B3    = 3'd4,
    CFG_A1    = 3'd5,
    CFG_A2    = 3'd6,
    CFG_A3    = 3'd7
  } cfg_idx_e;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic load;    // register b*x for the coming update
    logic update;  // cell lies inside the order in use: take new state
    logic tail;    // last cell in use: no neighbor term
    logic wr;      // direct state write
  } cell_ctl_t;

endpackage

/* hw/rtl/iir_filter_transposed_df2_core.sv */
// Top level of the transposed direct form II IIR filter: config registers,
// output stage, sequencer and the chain of delay cells.
// Depends on iirtdf2_pkg and iirtdf2_cell.
//
//   channel | signals                                      | direction
//   --------+----------------------------------------------+----------
//   input   | in_valid_i / in_stall_o, cmd, sample, delay  | in
//   output  | out_valid_o / out_stall_i, sample, delay, sat| out
//   config  | cfg_we_i, cfg_idx_i, cfg_data_i              | in
//
// A filter beat runs in ST_IDLE and then ST_UPDATE: the first forms y from b0*x and delay 0
// while every cell registers b*x; in ST_UPDATE the cells within the order update in
// parallel on a*y. Write and read beats post their result straight from ST_IDLE.
// Reset clears the delay line, the order and the coefficients (b0 = 1.0).
// A result waits in the output register while out_stall_i is high; a new beat is
// taken when the sequencer is idle and that register is empty or drains in the same cycle.
`timescale 1ns / 1ps

module iir_filter_transposed_df2_core #(
  parameter int MAX_ORDER = 3
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // configuration
  input  logic                                       cfg_we_i,
  input  logic [iirtdf2_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [iirtdf2_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  // input channel
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  logic [iirtdf2_pkg::CMD_W-1:0]              cmd_i,
  input  logic signed [iirtdf2_pkg::SMP_W-1:0]       sample_in_i,
  input  logic [iirtdf2_pkg::IDX_W-1:0]              delay_index_i,
  input  logic signed [iirtdf2_pkg::DLY_W-1:0]       delay_value_i,
  // output channel
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output logic signed [iirtdf2_pkg::SMP_W-1:0]       sample_out_o,
  output logic signed [iirtdf2_pkg::DLY_W-1:0]       delay_out_o,
  output logic                                       saturated_o
);

  localparam int SMP_W  = iirtdf2_pkg::SMP_W;
  localparam int COEF_W = iirtdf2_pkg::COEF_W;
  localparam int DLY_W  = iirtdf2_pkg::DLY_W;
  localparam int ORD_W  = iirtdf2_pkg::ORD_W;
  localparam int ACC_W  = DLY_W + 1;
  localparam int YF_W   = ACC_W - iirtdf2_pkg::FRAC_W;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [ORD_W-1:0]         order_q;
  logic signed [COEF_W-1:0] coef_b_q [iirtdf2_pkg::NUM_TAPS+1];
  logic signed [COEF_W-1:0] coef_a_q [iirtdf2_pkg::NUM_TAPS];  // a1..a3

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q     <= '0;
      coef_b_q[0] <= iirtdf2_pkg::B0_RESET;
      coef_b_q[1] <= '0;
      coef_b_q[2] <= '0;
      coef_b_q[3] <= '0;
      coef_a_q[0] <= '0;
      coef_a_q[1] <= '0;
      coef_a_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (iirtdf2_pkg::cfg_idx_e'(cfg_idx_i))
        iirtdf2_pkg::CFG_ORDER: order_q     <= cfg_data_i[ORD_W-1:0];
        iirtdf2_pkg::CFG_B0:    coef_b_q[0] <= cfg_data_i;
        iirtdf2_pkg::CFG_B1:    coef_b_q[1] <= cfg_data_i;
        iirtdf2_pkg::CFG_B2:    coef_b_q[2] <= cfg_data_i;
        iirtdf2_pkg::CFG_B3:    coef_b_q[3] <= cfg_data_i;
        iirtdf2_pkg::CFG_A1:    coef_a_q[0] <= cfg_data_i;
        iirtdf2_pkg::CFG_A2:    coef_a_q[1] <= cfg_data_i;
        iirtdf2_pkg::CFG_A3:    coef_a_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the order to the cells actually built.
  logic [ORD_W-1:0] n_eff;
  assign n_eff = (int'(order_q) > MAX_ORDER) ? ORD_W'(MAX_ORDER) : order_q;

  // ---------------------------------------------------------------------
  // Handshake and sequencer
  // ---------------------------------------------------------------------
  state_e state_q;
  logic   out_valid_q;
  logic   in_acc;
  logic   out_taken;
  logic   out_set;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_taken  = out_valid_q && !out_stall_i;
  // post a result for a write, read or unknown beat, or at the end of a filter beat
  assign out_set    = (state_q == ST_UPDATE) ||
                      (in_acc && (cmd_i != iirtdf2_pkg::CMD_FILTER));

  // ---------------------------------------------------------------------
  // First step: y = sat16(floor((z0 + b0*x) / 2^14))
  // ---------------------------------------------------------------------
  logic signed [DLY_W-1:0]                z_all [MAX_ORDER];
  logic [MAX_ORDER-1:0]                   clip_all;
  logic signed [iirtdf2_pkg::PROD_W-1:0]  prod0;
  logic signed [ACC_W-1:0]                acc;
  logic signed [YF_W-1:0]                 y_full;
  logic signed [SMP_W-1:0]                y_sat;
  logic                                   y_clip;

  assign prod0 = coef_b_q[0] * sample_in_i;

  always_comb begin
    acc    = ACC_W'(prod0) + ((n_eff != '0) ? ACC_W'(z_all[0]) : ACC_W'(0));
    y_full = acc[ACC_W-1:iirtdf2_pkg::FRAC_W];
    y_clip = (y_full[YF_W-1:SMP_W-1] != {(YF_W-SMP_W+1){y_full[YF_W-1]}});
    if (y_clip) begin
      y_sat = y_full[YF_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
    end else begin
      y_sat = y_full[SMP_W-1:0];
    end
  end

  // Read mux over the cells; an index past the chain reads zero.
  logic signed [DLY_W-1:0] rd_data;
  always_comb begin
    rd_data = '0;
    for (int j = 0; j < MAX_ORDER; j++) begin
      if (int'(delay_index_i) == j) begin
        rd_data = z_all[j];
      end
    end
  end

  // ---------------------------------------------------------------------
  // State and output register
  // ---------------------------------------------------------------------
  logic signed [SMP_W-1:0] y_q;
  logic                    y_clip_q;
  logic signed [SMP_W-1:0] sample_out_q;
  logic signed [DLY_W-1:0] delay_out_q;
  logic                    saturated_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      y_q          <= '0;
      y_clip_q     <= 1'b0;
      sample_out_q <= '0;
      delay_out_q  <= '0;
      saturated_q  <= 1'b0;
    end else begin
      // post a new result, or drop the one just taken
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_taken) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (cmd_i)
              iirtdf2_pkg::CMD_FILTER: begin
                // hold y for the cell update, post the result next cycle
                y_q      <= y_sat;
                y_clip_q <= y_clip;
                state_q  <= ST_UPDATE;
              end
              iirtdf2_pkg::CMD_READ: begin
                sample_out_q <= '0;
                delay_out_q  <= rd_data;
                saturated_q  <= 1'b0;
              end
              default: begin
                // write beat or unknown command: all-zero result
                sample_out_q <= '0;
                delay_out_q  <= '0;
                saturated_q  <= 1'b0;
              end
            endcase
          end
        end
        ST_UPDATE: begin
          // output register is empty here: it was free when the beat came in
          sample_out_q <= y_q;
          delay_out_q  <= '0;
          saturated_q  <= y_clip_q | (|clip_all);
          state_q      <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign delay_out_o  = delay_out_q;
  assign saturated_o  = saturated_q;

  // ---------------------------------------------------------------------
  // Chain of delay cells: cell j takes z(j+1) from its right neighbor
  // ---------------------------------------------------------------------
  logic is_filter;
  logic is_write;
  assign is_filter = in_acc && (cmd_i == iirtdf2_pkg::CMD_FILTER);
  assign is_write  = in_acc && (cmd_i == iirtdf2_pkg::CMD_WRITE);

  for (genvar j = 0; j < MAX_ORDER; j++) begin : g_cell
    iirtdf2_pkg::cell_ctl_t   ctl;
    logic signed [COEF_W-1:0] cb, ca;
    logic signed [DLY_W-1:0]  z_next;

    if (j < iirtdf2_pkg::NUM_TAPS) begin : g_coef
      assign cb = coef_b_q[j+1];
      assign ca = coef_a_q[j];
    end else begin : g_nocoef
      assign cb = '0;
      assign ca = '0;
    end

    if (j + 1 < MAX_ORDER) begin : g_link
      assign z_next = z_all[j+1];
    end else begin : g_end
      assign z_next = '0;
    end

    assign ctl.load   = is_filter;
    assign ctl.update = (state_q == ST_UPDATE) && (j < int'(n_eff));
    assign ctl.tail   = (j + 1 == int'(n_eff));
    assign ctl.wr     = is_write && (int'(delay_index_i) == j);

    iirtdf2_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .coef_b_i  (cb),
      .coef_a_i  (ca),
      .x_i       (sample_in_i),
      .y_i       (y_q),
      .z_next_i  (z_next),
      .wr_data_i (delay_value_i),
      .z_o       (z_all[j]),
      .clip_o    (clip_all[j])
    );
  end

endmodule

/* hw/rtl/iirtdf2_cell.sv */
// One delay cell of the transposed direct form II chain.
// Depends on iirtdf2_pkg.
`timescale 1ns / 1ps

module iirtdf2_cell (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  iirtdf2_pkg::cell_ctl_t                   ctl_i,
  input  logic signed [iirtdf2_pkg::COEF_W-1:0]    coef_b_i,
  input  logic signed [iirtdf2_pkg::COEF_W-1:0]    coef_a_i,
  input  logic signed [iirtdf2_pkg::SMP_W-1:0]     x_i,
  input  logic signed [iirtdf2_pkg::SMP_W-1:0]     y_i,
  input  logic signed [iirtdf2_pkg::DLY_W-1:0]     z_next_i,
  input  logic signed [iirtdf2_pkg::DLY_W-1:0]     wr_data_i,
  output logic signed [iirtdf2_pkg::DLY_W-1:0]     z_o,
  output logic                                     clip_o
);

  localparam int SUM_W = iirtdf2_pkg::DLY_W + 2;

  logic signed [iirtdf2_pkg::DLY_W-1:0]  z_q, z_d;
  logic signed [iirtdf2_pkg::PROD_W-1:0] bx_q, bx_d, ay;
  logic signed [SUM_W-1:0]               sum;
  logic                                  ovf;

  assign bx_d = coef_b_i * x_i;
  assign ay   = coef_a_i * y_i;

  always_comb begin
    sum = (ctl_i.tail ? SUM_W'(0) : SUM_W'(z_next_i)) + SUM_W'(bx_q) - SUM_W'(ay);
    ovf = (sum[SUM_W-1:iirtdf2_pkg::DLY_W-1] != {3{sum[SUM_W-1]}});
    z_d = z_q;
    if (ctl_i.wr) begin
      z_d = wr_data_i;
    end else if (ctl_i.update) begin
      if (ovf) begin
        z_d = sum[SUM_W-1] ? {1'b1, {(iirtdf2_pkg::DLY_W-1){1'b0}}}
                           : {1'b0, {(iirtdf2_pkg::DLY_W-1){1'b1}}};
      end else begin
        z_d = sum[iirtdf2_pkg::DLY_W-1:0];
      end
    end
  end

  assign clip_o = ctl_i.update & ovf;
  assign z_o    = z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_q <= '0;
    end else begin
      z_q <= z_d;
    end
  end

  // Product holds between its load and the update.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      bx_q <= bx_d;
    end
  end

endmodule

/* bench/tb_top.sv */
// Self-checking bench for iir_filter_transposed_df2_core: random and directed beats,
// with a bit-true filter model in the bench and random idling on both channels.
// Depends on iirtdf2_pkg and the filter core RTL.
`timescale 1ns / 1ps

module tb_top;
  import iirtdf2_pkg::*;

  localparam int MAX_ORDER = 3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int PRINT_CAP = 40;

  // cmd 3 is not a command of the block; it must give an all-zero beat
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  localparam longint SMP_HI = 32767;
  localparam longint SMP_LO = -32768;
  localparam longint DLY_HI = (longint'(1) << (DLY_W - 1)) - 1;
  localparam longint DLY_LO = -(longint'(1) << (DLY_W - 1));
  localparam logic signed [COEF_W-1:0] COEF_MAX = 18'sd131071;
  localparam logic signed [COEF_W-1:0] COEF_MIN = -18'sd131072;

  typedef struct packed {
    logic signed [SMP_W-1:0] y;
    logic signed [DLY_W-1:0] dly;
    logic                    sat;
  } beat_out_t;

  // DUT ports: every input starts at a known value
  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i = CFG_ORDER;
  logic [CFG_DATA_W-1:0]    cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [CMD_W-1:0]         cmd_i = CMD_FILTER;
  logic signed [SMP_W-1:0]  sample_in_i = '0;
  logic [IDX_W-1:0]         delay_index_i = '0;
  logic signed [DLY_W-1:0]  delay_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [SMP_W-1:0]  sample_out_o;
  logic signed [DLY_W-1:0]  delay_out_o;
  logic                     saturated_o;

  // Filter state as the bench sees it
  logic [ORD_W-1:0]         ord_cfg;
  logic signed [COEF_W-1:0] ff_coef [0:3];
  logic signed [COEF_W-1:0] fb_coef [1:3];
  logic signed [DLY_W-1:0]  dly_line [0:MAX_ORDER-1];

  beat_out_t due_outputs [$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  settings_applied = 0;
  int  beats_by_cmd [4] = '{default: 0};
  int  cycle_cnt = 0;
  bit  in_calm = 1'b0;
  bit  out_calm = 1'b0;
  bit  dense_send = 1'b0;
  int  hold_request = 0;

  iir_filter_transposed_df2_core #(
    .MAX_ORDER(MAX_ORDER)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .sample_in_i  (sample_in_i),
    .delay_index_i(delay_index_i),
    .delay_value_i(delay_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .delay_out_o  (delay_out_o),
    .saturated_o  (saturated_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Filter model: advance the bench copy of the delay line by one beat and
  // return the beat the block must produce for it.
  // ---------------------------------------------------------------------------
  function automatic beat_out_t iir_tdf2_step(logic [CMD_W-1:0] cmd,
                                              logic signed [SMP_W-1:0] x,
                                              logic [IDX_W-1:0] idx,
                                              logic signed [DLY_W-1:0] val);
    beat_out_t r;
    longint    acc;
    longint    y;
    longint    nxt;
    int        n;
    r = '0;
    case (cmd)
      CMD_FILTER: begin
        n = (int'(ord_cfg) > MAX_ORDER) ? MAX_ORDER : int'(ord_cfg);
        acc = longint'(ff_coef[0]) * longint'(x);
        if (n > 0) acc += longint'(dly_line[0]);
        // arithmetic shift floors toward minus infinity
        y = acc >>> FRAC_W;
        if (y > SMP_HI) begin
          y = SMP_HI;
          r.sat = 1'b1;
        end else if (y < SMP_LO) begin
          y = SMP_LO;
          r.sat = 1'b1;
        end
        // ascending j reads dly_line[j+1] before it is overwritten
        for (int j = 0; j < n; j++) begin
          nxt = longint'(ff_coef[j+1]) * longint'(x) - longint'(fb_coef[j+1]) * y;
          if (j + 1 < n) nxt += longint'(dly_line[j+1]);
          if (nxt > DLY_HI) begin
            nxt = DLY_HI;
            r.sat = 1'b1;
          end else if (nxt < DLY_LO) begin
            nxt = DLY_LO;
            r.sat = 1'b1;
          end
          dly_line[j] = nxt[DLY_W-1:0];
        end
        r.y = y[SMP_W-1:0];
      end
      CMD_WRITE: begin
        if (idx < MAX_ORDER) dly_line[idx] = val;
      end
      CMD_READ: begin
        if (idx < MAX_ORDER) r.dly = dly_line[idx];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random value helpers
  // ---------------------------------------------------------------------------
  // Mostly no gap or a short one, now and then a long one; none while calm.
  function automatic int pick_idle(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [SMP_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'(SMP_HI);
      1: return 16'(SMP_LO);
      2, 3, 4: return 16'(int'($urandom_range(0, 512)) - 256);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic signed [DLY_W-1:0] rand_delay();
    logic [63:0] w;
    int          r;
    r = $urandom_range(0, 9);
    w = {$urandom(), $urandom()};
    case (r)
      0: return DLY_W'(DLY_HI);
      1: return DLY_W'(DLY_LO);
      2, 3, 4: return DLY_W'(longint'($urandom_range(0, 2097152)) - 1048576);
      default: return w[DLY_W-1:0];
    endcase
  endfunction

  // Full range, rail values, or something small, within plus or minus 0.5.
  function automatic logic signed [COEF_W-1:0] rand_coef();
    int r;
    r = $urandom_range(0, 5);
    case (r)
      0: return COEF_MAX;
      1: return COEF_MIN;
      2, 3: return COEF_W'(int'($urandom_range(0, 16384)) - 8192);
      default: return COEF_W'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Shared channel tasks
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] result %0d: %s got %0d, want %0d", $time, results_seen, what,
               got, want);
  endtask

  // Offer one beat after a random gap and hold it until the block takes it.
  // Valid stays high on return so back-to-back beats need no extra edge.
  task automatic send_beat(logic [CMD_W-1:0] cmd, logic signed [SMP_W-1:0] smp,
                           logic [IDX_W-1:0] idx, logic signed [DLY_W-1:0] val);
    int gap;
    gap = dense_send ? 0 : pick_idle(in_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    sample_in_i   <= smp;
    delay_index_i <= idx;
    delay_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    due_outputs.push_back(iir_tdf2_step(cmd, smp, idx, val));
    beats_by_cmd[cmd]++;
  endtask

  // Drop valid and wait for every pending result.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write one register; the caller lowers the write enable after a batch.
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_ORDER: ord_cfg    = data[ORD_W-1:0];
      CFG_B0:    ff_coef[0] = data;
      CFG_B1:    ff_coef[1] = data;
      CFG_B2:    ff_coef[2] = data;
      CFG_B3:    ff_coef[3] = data;
      CFG_A1:    fb_coef[1] = data;
      CFG_A2:    fb_coef[2] = data;
      CFG_A3:    fb_coef[3] = data;
      default: begin
      end
    endcase
  endtask

  // Load a complete setting while the block is idle. Junk in the upper
  // bits of the order write must be dropped by the block.
  task automatic apply_setting(logic [ORD_W-1:0] ord,
                               logic signed [COEF_W-1:0] b0, logic signed [COEF_W-1:0] b1,
                               logic signed [COEF_W-1:0] b2, logic signed [COEF_W-1:0] b3,
                               logic signed [COEF_W-1:0] a1, logic signed [COEF_W-1:0] a2,
                               logic signed [COEF_W-1:0] a3);
    drain();
    write_reg(CFG_ORDER, {(CFG_DATA_W - ORD_W)'($urandom()), ord});
    write_reg(CFG_B0, b0);
    write_reg(CFG_B1, b1);
    write_reg(CFG_B2, b2);
    write_reg(CFG_B3, b3);
    write_reg(CFG_A1, a1);
    write_reg(CFG_A2, a2);
    write_reg(CFG_A3, a3);
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset state: empty delay line, order zero, unity gain.
  task automatic test_reset_defaults();
    for (int k = 0; k <= MAX_ORDER; k++) send_beat(CMD_READ, '0, IDX_W'(k), '0);
    send_beat(CMD_FILTER, 16'(SMP_HI), '0, '0);
    send_beat(CMD_FILTER, 16'(SMP_LO), '0, '0);
    send_beat(CMD_UNKNOWN, 16'(SMP_HI), 2'd1, DLY_W'(DLY_HI));
  endtask

  // Rail coefficients, rail delay contents and rail samples: drive the output
  // and every delay update into saturation, and hit the out-of-range index.
  task automatic test_edge_values();
    apply_setting(2'd3, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN,
                  COEF_MAX, COEF_MIN, COEF_MAX);
    send_beat(CMD_WRITE, '0, 2'd0, DLY_W'(DLY_HI));
    send_beat(CMD_WRITE, '0, 2'd1, DLY_W'(DLY_LO));
    send_beat(CMD_WRITE, '0, 2'd2, DLY_W'(DLY_HI));
    send_beat(CMD_WRITE, '0, 2'd3, DLY_W'(40'h55_5555_5555));
    for (int k = 0; k <= MAX_ORDER; k++) send_beat(CMD_READ, '0, IDX_W'(k), '0);
    send_beat(CMD_FILTER, 16'(SMP_HI), '0, '0);
    send_beat(CMD_FILTER, 16'(SMP_LO), '0, '0);
    send_beat(CMD_FILTER, 16'sd0, '0, '0);
    send_beat(CMD_FILTER, 16'sd1, '0, '0);
    send_beat(CMD_FILTER, -16'sd1, '0, '0);
    for (int k = 0; k < MAX_ORDER; k++) send_beat(CMD_READ, '0, IDX_W'(k), '0);
    // a lower order must leave the delays above it alone
    apply_setting(2'd1, COEF_MIN, 18'sd8192, '0, '0, COEF_MIN, '0, '0);
    send_beat(CMD_FILTER, 16'(SMP_LO), '0, '0);
    send_beat(CMD_READ, '0, 2'd2, '0);
  endtask

  // Mostly filter beats with random content; state writes, read-backs and
  // unknown commands mixed in. Each phase runs under a fresh setting.
  task automatic test_random_traffic(int phases);
    int                      mode;
    int                      r;
    logic signed [COEF_W-1:0] c [0:6];
    for (int p = 0; p < phases; p++) begin
      mode = $urandom_range(0, 5);
      for (int k = 0; k < 7; k++)
        c[k] = (mode == 0) ? COEF_MAX : (mode == 1) ? COEF_MIN : rand_coef();
      apply_setting(ORD_W'($urandom_range(0, 3)), c[0], c[1], c[2], c[3],
                    c[4], c[5], c[6]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(0, 99);
        if (r < 78)
          send_beat(CMD_FILTER, rand_sample(), IDX_W'($urandom()), rand_delay());
        else if (r < 87)
          send_beat(CMD_WRITE, rand_sample(), IDX_W'($urandom_range(0, 3)), rand_delay());
        else if (r < 96)
          send_beat(CMD_READ, rand_sample(), IDX_W'($urandom_range(0, 3)), rand_delay());
        else
          send_beat(CMD_UNKNOWN, rand_sample(), IDX_W'($urandom()), rand_delay());
      end
    end
  endtask

  // Hold the output for a long stretch while beats keep coming back to back,
  // so the block fills and stalls its input.
  task automatic test_output_hold_off();
    hold_request = 300;
    dense_send = 1'b1;
    repeat (30) send_beat(CMD_FILTER, rand_sample(), '0, '0);
    dense_send = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stall bursts, calm stretches, and a long hold-off on
  // request. Counts its own cycles.
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    int n;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        n = pick_idle(out_calm);
        out_stall_i <= (n > 0);
        stall_left = (n > 0) ? n - 1 : 0;
      end
    end
  end

  // Switch either side between calm and idling stretches now and then.
  initial begin
    forever begin
      repeat ($urandom_range(150, 500)) @(negedge clk_i);
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
    end
  end

  // Compare each accepted result beat against the oldest pending one.
  always @(posedge clk_i) begin : check_results
    beat_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (due_outputs.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = due_outputs.pop_front();
        if (sample_out_o !== want.y)
          report_mismatch("sample_out", longint'(sample_out_o), longint'(want.y));
        if (delay_out_o !== want.dly)
          report_mismatch("delay_out", longint'(delay_out_o), longint'(want.dly));
        if (saturated_o !== want.sat)
          report_mismatch("saturated", longint'(saturated_o), longint'(want.sat));
      end
    end
  end

  // Cycle limit: far above the slowest correct run.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
             due_outputs.size());
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    ord_cfg = '0;
    ff_coef = '{B0_RESET, '0, '0, '0};
    fb_coef = '{default: '0};
    dly_line = '{default: '0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_edge_values();
    test_random_traffic(4);
    test_output_hold_off();
    test_random_traffic(4);

    drain();
    repeat (8) @(posedge clk_i);
    if (due_outputs.size() != 0) report_mismatch("results never delivered",
                                                 0, due_outputs.size());
    $display("covered %0d filter, %0d write, %0d read, %0d unknown beats under %0d settings",
             beats_by_cmd[CMD_FILTER], beats_by_cmd[CMD_WRITE], beats_by_cmd[CMD_READ],
             beats_by_cmd[CMD_UNKNOWN], settings_applied);
    $display("checked %0d results in %0d cycles, %0d mismatches", results_seen, cycle_cnt,
             mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
